// File: src/lslf_pkg.sv
// Shared widths, codes and controller/datapath handshake types for the line fit.
package lslf_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_W        = 24;
  localparam int unsigned SUM1_W         = 30;
  localparam int unsigned SQ_W           = 53;
  localparam int unsigned XY_W           = 54;
  localparam int unsigned ACC_W          = 112;
  localparam int unsigned MB_W           = 32;
  localparam int unsigned REM_W          = 60;
  localparam int unsigned FRAC_EXTRA     = 16;
  localparam int unsigned MAC_STEPS      = MB_W;
  localparam int unsigned DIV_STEPS      = ACC_W;
  localparam int unsigned STEP_W         = 7;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FEW,
    ST_ZERO_DEN,
    ST_OVERFLOW
  } status_e;

  typedef enum logic [2:0] {
    OP_N_SXX,
    OP_SX_SX,
    OP_N_SXY,
    OP_SY_SX,
    OP_SXX_SY,
    OP_SXY_SX,
    OP_FIT
  } mac_op_e;

  typedef enum logic [1:0] {
    OUT_FIT,
    OUT_PAIR,
    OUT_ERR
  } out_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_CHECK,
    S_MAC_LD,
    S_MAC_RUN,
    S_DELTA_CHK,
    S_DIV_LD,
    S_DIV_RUN,
    S_DIV_END,
    S_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     accum;
    logic     clear_set;
    logic     mac_load;
    mac_op_e  mac_op;
    logic     mac_step;
    logic     mac_msb;
    logic     save_delta;
    logic     div_load;
    logic     div_step;
    logic     save_slope;
    logic     save_icpt;
    logic     out_load;
    out_sel_e out_sel;
    status_e  out_status;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic overflow;
    logic cnt_lt2;
    logic cnt_eq2;
    logic p_pos;
    logic idx_last;
  } dp_sts_t;

endpackage

// File: src/lslf_if.sv
// Valid/ready channel interfaces for points in and fitted results out.
interface lslf_in_if import lslf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_val;
  logic                      last_point;

  modport source (output valid, x_pos, y_val, last_point, input ready);
  modport sink   (input valid, x_pos, y_val, last_point, output ready);
endinterface

interface lslf_out_if import lslf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] fitted_y;
  logic                      is_last;
  logic [1:0]                status;

  modport source (output valid, fitted_y, is_last, status, input ready);
  modport sink   (input valid, fitted_y, is_last, status, output ready);
endinterface

// File: src/lslf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lslf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/lslf_ctrl.sv
// Sequencer for point loading, the shared multiply and divide passes, and result output.
module lslf_ctrl import lslf_pkg::*; #(
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dp_sts_t       sts_i,
  output dp_cmd_t       cmd_o,
  output logic [AW-1:0] idx_o
);
  state_e              state_q, state_d;
  mac_op_e             op_q, op_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                last_q, last_d;
  out_sel_e            sel_q, sel_d;
  status_e             code_q, code_d;
  logic                olast_q, olast_d;
  logic                accept;
  logic                mac_msb;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign mac_msb = (step_q == STEP_W'(MAC_STEPS - 1));
  assign idx_o   = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_N_SXX;
      step_q  <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      sel_q   <= OUT_FIT;
      code_q  <= ST_OK;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      sel_q   <= sel_d;
      code_q  <= code_d;
      olast_q <= olast_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    idx_d   = idx_q;
    last_d  = last_q;
    sel_d   = sel_q;
    code_d  = code_q;
    olast_d = olast_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = in_last_i;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = last_q ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (sts_i.overflow) begin
          sel_d   = OUT_ERR;
          code_d  = ST_OVERFLOW;
          state_d = S_OUT_LD;
        end else if (sts_i.cnt_lt2) begin
          sel_d   = OUT_ERR;
          code_d  = ST_FEW;
          state_d = S_OUT_LD;
        end else if (sts_i.cnt_eq2) begin
          sel_d   = OUT_PAIR;
          idx_d   = '0;
          state_d = S_RD;
        end else begin
          op_d    = OP_N_SXX;
          state_d = S_MAC_LD;
        end
      end
      S_MAC_LD: begin
        step_d  = '0;
        state_d = S_MAC_RUN;
      end
      S_MAC_RUN: begin
        if (mac_msb) begin
          case (op_q)
            OP_N_SXX: begin
              op_d    = OP_SX_SX;
              state_d = S_MAC_LD;
            end
            OP_SX_SX:  state_d = S_DELTA_CHK;
            OP_N_SXY: begin
              op_d    = OP_SY_SX;
              state_d = S_MAC_LD;
            end
            OP_SY_SX:  state_d = S_DIV_LD;
            OP_SXX_SY: begin
              op_d    = OP_SXY_SX;
              state_d = S_MAC_LD;
            end
            OP_SXY_SX: state_d = S_DIV_LD;
            OP_FIT: begin
              sel_d   = OUT_FIT;
              state_d = S_OUT_LD;
            end
            default:   state_d = S_IDLE;
          endcase
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DELTA_CHK: begin
        if (sts_i.p_pos) begin
          op_d    = OP_N_SXY;
          state_d = S_MAC_LD;
        end else begin
          sel_d   = OUT_ERR;
          code_d  = ST_ZERO_DEN;
          state_d = S_OUT_LD;
        end
      end
      S_DIV_LD: begin
        step_d  = '0;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_DIV_END;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV_END: begin
        if (op_q == OP_SY_SX) begin
          op_d    = OP_SXX_SY;
          state_d = S_MAC_LD;
        end else begin
          idx_d   = '0;
          sel_d   = OUT_FIT;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sel_q == OUT_PAIR) begin
          state_d = S_OUT_LD;
        end else begin
          op_d    = OP_FIT;
          state_d = S_MAC_LD;
        end
      end
      S_OUT_LD: begin
        olast_d = (sel_q == OUT_ERR) || sts_i.idx_last;
        state_d = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.mac_op     = op_q;
    cmd_o.out_sel    = sel_q;
    cmd_o.out_status = (sel_q == OUT_ERR) ? code_q : ST_OK;
    cmd_o.out_last   = (sel_q == OUT_ERR) || sts_i.idx_last;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = accept;
      end
      S_ACC:       cmd_o.accum = 1'b1;
      S_MAC_LD:    cmd_o.mac_load = 1'b1;
      S_MAC_RUN: begin
        cmd_o.mac_step = 1'b1;
        cmd_o.mac_msb  = mac_msb;
      end
      S_DELTA_CHK: cmd_o.save_delta = sts_i.p_pos;
      S_DIV_LD:    cmd_o.div_load = 1'b1;
      S_DIV_RUN:   cmd_o.div_step = 1'b1;
      S_DIV_END: begin
        cmd_o.save_slope = (op_q == OP_SY_SX);
        cmd_o.save_icpt  = (op_q != OP_SY_SX);
      end
      S_OUT_LD:    cmd_o.out_load = 1'b1;
      S_OUT_WAIT: begin
        out_valid_o     = 1'b1;
        cmd_o.clear_set = out_ready_i && olast_q;
      end
      default: ;
    endcase
  end
endmodule

// File: src/lslf_dp.sv
// Point store, running sums, shift-add multiplier, restoring divider and output register.
module lslf_dp import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned AW         = $clog2(MAX_POINTS),
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  input  logic [AW-1:0]             idx_i,
  input  logic signed [COORD_W-1:0] x_pos_i,
  input  logic signed [COORD_W-1:0] y_val_i,
  output dp_sts_t                   sts_o,
  output logic signed [COORD_W-1:0] fitted_y_o,
  output logic                      is_last_o,
  output logic [1:0]                status_o
);
  localparam int unsigned SH_W = ACC_W - FRAC_EXTRA;

  logic [CW-1:0]              cnt_q;
  logic                       ovf_q;
  logic signed [SUM1_W-1:0]   sx_q, sy_q;
  logic [SQ_W-1:0]            sxx_q;
  logic signed [XY_W-1:0]     sxy_q;
  logic signed [COORD_W-1:0]  px_q, py_q;
  logic                       pst_q;
  logic signed [ACC_W-1:0]    p_q, a_q, slope_q, icpt_q;
  logic signed [MB_W-1:0]     b_q;
  logic [REM_W-1:0]           delta_q, rem_q;
  logic                       neg_q;
  logic signed [COORD_W-1:0]  fit_q;
  logic                       last_q;
  logic [1:0]                 stat_q;

  logic                       store;
  logic [2*COORD_W-1:0]       rdata;
  logic signed [COORD_W-1:0]  rd_x, rd_y;
  logic signed [2*COORD_W-1:0] xx, xy;
  logic signed [ACC_W-1:0]    a_val, addend, p_mag;
  logic signed [MB_W-1:0]     b_val;
  logic                       a_neg;
  logic [REM_W:0]             trial;
  logic                       qbit;
  logic [SH_W-1:0]            sh;
  logic signed [COORD_W-1:0]  narrow;

  assign store = (cnt_q < CW'(MAX_POINTS));

  lslf_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && store),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({x_pos_i, y_val_i}),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[2*COORD_W-1:COORD_W];
  assign rd_y = rdata[COORD_W-1:0];
  assign xx   = px_q * px_q;
  assign xy   = px_q * py_q;

  // operand choice for each multiply pass
  always_comb begin
    a_val = '0;
    b_val = '0;
    a_neg = 1'b0;
    case (cmd_i.mac_op)
      OP_N_SXX: begin
        a_val = ACC_W'(sxx_q);
        b_val = MB_W'(cnt_q);
      end
      OP_SX_SX: begin
        a_val = ACC_W'(sx_q);
        b_val = MB_W'(sx_q);
        a_neg = 1'b1;
      end
      OP_N_SXY: begin
        a_val = ACC_W'(sxy_q);
        b_val = MB_W'(cnt_q);
      end
      OP_SY_SX: begin
        a_val = ACC_W'(sy_q);
        b_val = MB_W'(sx_q);
        a_neg = 1'b1;
      end
      OP_SXX_SY: begin
        a_val = ACC_W'(sxx_q);
        b_val = MB_W'(sy_q);
      end
      OP_SXY_SX: begin
        a_val = ACC_W'(sxy_q);
        b_val = MB_W'(sx_q);
        a_neg = 1'b1;
      end
      OP_FIT: begin
        a_val = slope_q;
        b_val = MB_W'(rd_x);
      end
      default: ;
    endcase
  end

  // top bit of the multiplier has negative weight
  assign addend = a_q ^ {ACC_W{cmd_i.mac_msb}};
  assign p_mag  = p_q[ACC_W-1] ? -p_q : p_q;
  assign trial  = {rem_q, p_q[ACC_W-1]};
  assign qbit   = (trial >= {1'b0, delta_q});

  // drop the extra fraction bits toward zero, then clamp
  assign sh = p_mag[ACC_W-1:FRAC_EXTRA];
  always_comb begin
    if (p_q[ACC_W-1]) begin
      narrow = (sh > SH_W'(2**(COORD_W-1))) ? {1'b1, {(COORD_W-1){1'b0}}}
                                            : -sh[COORD_W-1:0];
    end else begin
      narrow = (sh > SH_W'(2**(COORD_W-1) - 1)) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                : sh[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      pst_q <= 1'b0;
    end else if (cmd_i.clear_set) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      pst_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pst_q <= store;
      if (store) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end else if (cmd_i.accum && pst_q) begin
      sx_q  <= sx_q + SUM1_W'(px_q);
      sy_q  <= sy_q + SUM1_W'(py_q);
      sxx_q <= sxx_q + SQ_W'($unsigned(xx));
      sxy_q <= sxy_q + XY_W'(xy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q <= x_pos_i;
      py_q <= y_val_i;
    end
    if (cmd_i.mac_load) begin
      a_q <= a_neg ? -a_val : a_val;
      b_q <= b_val;
      case (cmd_i.mac_op)
        OP_N_SXX, OP_N_SXY, OP_SXX_SY: p_q <= '0;
        OP_FIT:                        p_q <= icpt_q;
        default: ;
      endcase
    end else if (cmd_i.mac_step) begin
      if (b_q[0]) begin
        p_q <= p_q + addend + ACC_W'(cmd_i.mac_msb);
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >>> 1;
    end else if (cmd_i.div_load) begin
      neg_q <= p_q[ACC_W-1];
      p_q   <= p_mag << FRAC_EXTRA;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? REM_W'(trial - {1'b0, delta_q}) : trial[REM_W-1:0];
      p_q   <= {p_q[ACC_W-2:0], qbit};
    end
    if (cmd_i.save_delta) begin
      delta_q <= p_q[REM_W-1:0];
    end
    if (cmd_i.save_slope) begin
      slope_q <= neg_q ? -p_q : p_q;
    end
    if (cmd_i.save_icpt) begin
      icpt_q <= neg_q ? -p_q : p_q;
    end
    if (cmd_i.out_load) begin
      last_q <= cmd_i.out_last;
      stat_q <= cmd_i.out_status;
      case (cmd_i.out_sel)
        OUT_FIT:  fit_q <= narrow;
        OUT_PAIR: fit_q <= rd_y;
        default:  fit_q <= '0;
      endcase
    end
  end

  assign sts_o.overflow = ovf_q;
  assign sts_o.cnt_lt2  = (cnt_q < CW'(2));
  assign sts_o.cnt_eq2  = (cnt_q == CW'(2));
  assign sts_o.p_pos    = !p_q[ACC_W-1] && (|p_q);
  assign sts_o.idx_last = (CW'(idx_i) == cnt_q - 1'b1);

  assign fitted_y_o = fit_q;
  assign is_last_o  = last_q;
  assign status_o   = stat_q;
endmodule

// File: src/least_squares_line_fit.sv
// Least-squares line fit: top level joining the sequencer and the datapath.
// Loading: each point is accepted, then added to the sums; the input waits
// during the sum update and while a set is fitted or its results are sent.
// Fit of n>2 points: 6 shift-add passes and 2 divisions, then for each result
// a RAM read, a 32-step multiply and an output load. Two points: a RAM read,
// then an output load, per result. Error: one zero result, marked last.
// Reset (async, active low) clears the sums, count and sequencer; the point
// store is not cleared and only entries of the current set are read.
module least_squares_line_fit import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lslf_in_if.sink     in_i,
  lslf_out_if.source  out_o
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] idx;
  logic          in_ready;
  logic          out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  lslf_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_point),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  lslf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .CW         (CW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .x_pos_i    (in_i.x_pos),
    .y_val_i    (in_i.y_val),
    .sts_o      (sts),
    .fitted_y_o (out_o.fitted_y),
    .is_last_o  (out_o.is_last),
    .status_o   (out_o.status)
  );
endmodule

// File: src/lslf_checker.sv
// Port-level checks for the line fit, bound to the top level.
module lslf_checker import lslf_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] fitted_y_i,
  input logic                      is_last_i,
  input logic [1:0]                status_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fitted_y_i)
      && $stable(is_last_i) && $stable(status_i))
    else $error("result request changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> is_last_i && (fitted_y_i == '0))
    else $error("error result not a lone zero final result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input open while a result is pending");

  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !is_last_i |=> !in_ready_i)
    else $error("input reopened before the run finished");
endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .fitted_y_i  (out_o.fitted_y),
  .is_last_i   (out_o.is_last),
  .status_i    (out_o.status)
);
